// ----- rtl/dtt_pkg.sv -----
// Package for the deadline timer table: word types, operation and status codes,
// slot entry layout and the sequencer state type. No dependencies.
`default_nettype none

package dtt_pkg;

  localparam int SLOT_COUNT_DEF = 8;

  // Operation codes of an input word (code 3 is unused and dropped)
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Status codes of a result word
  localparam logic [2:0] ST_FIRED    = 3'd0;
  localparam logic [2:0] ST_NONE     = 3'd1;
  localparam logic [2:0] ST_ADDED    = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  // Configuration register indexes
  localparam logic REG_TICK_PERIOD = 1'b0;
  localparam logic REG_DELAY_SCALE = 1'b1;

  localparam logic [31:0] TICK_PERIOD_RST = 32'd1000;
  localparam logic [19:0] DELAY_SCALE_RST = 20'd1000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] delay_ms;
    logic [15:0] event_handle;
    logic [31:0] fine_count;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] fired_handle;
    logic [2:0]  slot_index;
    logic [63:0] time_now;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [15:0] handle;
  } slot_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ADD_FIND,
    S_ADD_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_END,
    S_EMIT
  } dtt_state_t;

endpackage

`default_nettype wire

// ----- rtl/dtt_slot_ram.sv -----
// Slot memory: one write port, one read port, registered read data.
// Depends on dtt_pkg for the slot entry layout.
`default_nettype none

module dtt_slot_ram
  import dtt_pkg::*;
#(
  parameter int DEPTH  = SLOT_COUNT_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire slot_entry_t       wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output slot_entry_t            rd_data
);

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dtt_core.sv -----
// Sequencer and datapath: coarse count, occupancy bits, slot scan and slot fill.
// Depends on dtt_pkg and dtt_slot_ram.
`default_nettype none

module dtt_core
  import dtt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_word,
  input  wire logic [31:0] tick_period,
  input  wire logic [19:0] delay_scale,
  input  wire logic        emit_ok,
  output logic             emit_valid,
  output out_word_t        emit_word
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  dtt_state_t state, state_next;

  logic [1:0]            op;
  logic [31:0]           delay_ms;
  logic [15:0]           handle;
  logic [31:0]           fine;
  logic [63:0]           coarse;
  logic [63:0]           now;
  logic [31:0]           span;
  logic [63:0]           dl_sum;
  logic [IDX_W-1:0]      idx;
  logic [SLOT_COUNT-1:0] occ;
  logic                  pend_valid;
  logic [15:0]           pend_handle;
  logic [IDX_W-1:0]      pend_slot;
  logic [2:0]            res_status;
  logic [IDX_W-1:0]      res_slot;

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  slot_entry_t           rd_data;
  slot_entry_t           wr_data;
  logic [51:0]           product;
  logic                  idx_last;
  logic                  fire;
  logic                  scan_go;
  logic                  add_bad;

  assign product  = delay_ms * delay_scale;
  assign idx_last = (idx == IDX_W'(SLOT_COUNT - 1));
  assign fire     = occ[idx] && (now >= rd_data.deadline);
  // a second firing needs the output free to push out the held one
  assign scan_go  = !(fire && pend_valid && !emit_ok);
  assign add_bad  = (delay_ms == 32'd0) || (handle == 16'd0);
  assign wr_data  = '{deadline: dl_sum, handle: handle};

  dtt_slot_ram #(
    .DEPTH  (SLOT_COUNT),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    emit_valid = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx;
    wr_en      = 1'b0;
    emit_word  = '{status: res_status, fired_handle: 16'd0, slot_index: 3'(res_slot),
                   time_now: now, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (in_word.operation)
            OP_TICK, OP_ADD, OP_CLEAR: state_next = S_PREP;
            default:                   state_next = S_IDLE;
          endcase
        end
      end
      S_PREP: begin
        unique case (op)
          OP_TICK: state_next = S_SCAN_RD;
          OP_ADD:  state_next = add_bad ? S_EMIT : S_ADD_FIND;
          default: state_next = S_EMIT;
        endcase
      end
      S_ADD_FIND: begin
        if (!occ[idx]) begin
          state_next = S_ADD_WR;
        end else if (idx_last) begin
          state_next = S_EMIT;
        end
      end
      S_ADD_WR: begin
        wr_en      = 1'b1;
        state_next = S_EMIT;
      end
      S_SCAN_RD: begin
        rd_en      = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        emit_word = '{status: ST_FIRED, fired_handle: pend_handle,
                      slot_index: 3'(pend_slot), time_now: now, last: 1'b0};
        if (scan_go) begin
          emit_valid = fire && pend_valid;
          if (idx_last) begin
            state_next = S_SCAN_END;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx + 1'b1;
          end
        end
      end
      S_SCAN_END: begin
        emit_valid = emit_ok;
        if (pend_valid) begin
          emit_word = '{status: ST_FIRED, fired_handle: pend_handle,
                        slot_index: 3'(pend_slot), time_now: now, last: 1'b1};
        end else begin
          emit_word = '{status: ST_NONE, fired_handle: 16'd0, slot_index: 3'd0,
                        time_now: now, last: 1'b1};
        end
        if (emit_ok) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        emit_valid = emit_ok;
        if (emit_ok) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // control state: coarse count, occupancy, held firing
  always_ff @(posedge clk) begin
    if (rst) begin
      coarse     <= 64'd0;
      occ        <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_word.operation == OP_TICK) begin
            coarse <= coarse + 64'(tick_period);
          end
        end
        S_PREP: begin
          pend_valid <= 1'b0;
          if (op == OP_CLEAR) begin
            occ <= '0;
          end
        end
        S_ADD_WR: begin
          occ[idx] <= 1'b1;
        end
        S_SCAN_CHK: begin
          if (scan_go && fire) begin
            occ[idx]   <= 1'b0;
            pend_valid <= 1'b1;
          end
        end
        S_SCAN_END: begin
          if (emit_ok) begin
            pend_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op       <= in_word.operation;
        delay_ms <= in_word.delay_ms;
        handle   <= in_word.event_handle;
        fine     <= in_word.fine_count;
      end
      S_PREP: begin
        now      <= coarse + 64'(fine);
        span     <= product[31:0];
        idx      <= '0;
        res_slot <= '0;
        unique case (op)
          OP_ADD:  res_status <= add_bad ? ST_REJECTED : ST_FULL;
          default: res_status <= ST_CLEARED;
        endcase
      end
      S_ADD_FIND: begin
        dl_sum <= now + 64'(span);
        if (occ[idx] && !idx_last) begin
          idx <= idx + 1'b1;
        end
      end
      S_ADD_WR: begin
        res_status <= ST_ADDED;
        res_slot   <= idx;
      end
      S_SCAN_CHK: begin
        if (scan_go) begin
          if (fire) begin
            pend_handle <= rd_data.handle;
            pend_slot   <= idx;
          end
          if (!idx_last) begin
            idx <= idx + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/deadline_timer_table.sv -----
// Top level of the deadline timer table: register port, output register, core.
// Depends on dtt_pkg, dtt_core and dtt_slot_ram.
//
//   channel   direction  handshake          word
//   in        to block   in_valid/in_stall  in_word   (in_word_t)
//   out       from block out_valid/out_stall out_word (out_word_t)
//   config    to block   APB psel/penable   pwdata    (tick_period @0, delay_scale @4)
//
// Sequence: one word at a time. A tick: accept, form now, first slot read, one slot
//   compare per cycle unless a second firing waits on the output, final word. An add:
//   accept, form now, one step per occupied slot passed over before the free one,
//   slot write (none on a full table), result word. Clear or rejected add: accept,
//   form now, result word. The slot memory's single read port sets the scan pace.
// Reset: rst clears the coarse count and all occupancy bits at once; no clearing pass.
// Stalls: out_stall holds the result in the output register; the scan waits on a
//   second firing until the held one can move, so no word is lost.
`default_nettype none

module deadline_timer_table
  import dtt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_word,
  // result words
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_word,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] tick_period;
  logic [19:0] delay_scale;
  logic        emit_ok;
  logic        emit_valid;
  out_word_t   emit_word;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  // Registers are written in the access phase only
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_PERIOD_RST;
      delay_scale <= DELAY_SCALE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_TICK_PERIOD: tick_period <= pwdata;
        REG_DELAY_SCALE: delay_scale <= pwdata[19:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TICK_PERIOD: prdata = tick_period;
      REG_DELAY_SCALE: prdata = {12'd0, delay_scale};
    endcase
  end

  // Output register: free when empty or being taken this cycle
  assign emit_ok = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      out_word <= emit_word;
    end
  end

  dtt_core #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .tick_period (tick_period),
    .delay_scale (delay_scale),
    .emit_ok     (emit_ok),
    .emit_valid  (emit_valid),
    .emit_word   (emit_word)
  );

endmodule

`default_nettype wire

// ----- rtl/dtt_checker.sv -----
// Port-level checks for the deadline timer table, bound to the top level.
// Depends on dtt_pkg and deadline_timer_table.
`default_nettype none

module dtt_checker
  import dtt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_word_t  in_word,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // a valid operation occupies the block for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall &&
    (in_word.operation == OP_TICK || in_word.operation == OP_ADD ||
     in_word.operation == OP_CLEAR) |=> in_stall)
    else $error("input taken again right after an operation");

  // a firing always names a live handle
  a_fired_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status == ST_FIRED |-> out_word.fired_handle != 16'd0)
    else $error("fired word with zero handle");

  // only firings carry a handle
  a_no_stray_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != ST_FIRED |-> out_word.fired_handle == 16'd0)
    else $error("handle on a non-firing word");

  // every status other than a firing ends its operation
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != ST_FIRED |-> out_word.last)
    else $error("single-word result not marked last");

endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
